[src/uv_chamber_cycle_controller_core_defines.svh]
// Assertion macros used by the checker file of the UV chamber controller.
`ifndef UV_CHAMBER_CYCLE_CONTROLLER_CORE_DEFINES_SVH
`define UV_CHAMBER_CYCLE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UVC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/uvc_pkg.sv]
// Types and constants of the UV chamber cycle controller.
package uvc_pkg;

	// Published state codes, in sequence order.
	localparam logic [2:0] STATE_INIT     = 3'd0;
	localparam logic [2:0] STATE_OPENING  = 3'd1;
	localparam logic [2:0] STATE_WAIT_OBJ = 3'd2;
	localparam logic [2:0] STATE_VERIFY   = 3'd3;
	localparam logic [2:0] STATE_ACTIVE   = 3'd4;
	localparam logic [2:0] STATE_RELEASE  = 3'd5;
	localparam logic [2:0] STATE_FAULTED  = 3'd6;

	// Fault codes.
	localparam logic [2:0] FAULT_NONE        = 3'd0;
	localparam logic [2:0] FAULT_MANUAL_STOP = 3'd1;
	localparam logic [2:0] FAULT_DOOR_AJAR   = 3'd2;
	localparam logic [2:0] FAULT_TIMER       = 3'd3;
	localparam logic [2:0] FAULT_INVALID     = 3'd4;
	localparam logic [2:0] FAULT_UNSET       = 3'd5;

	// Remote commands.
	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_START   = 2'd1;
	localparam logic [1:0] CMD_END     = 2'd2;
	localparam logic [1:0] CMD_RELEASE = 2'd3;

	// Cycle timer status.
	localparam logic [1:0] TIMER_RUNNING = 2'd0;
	localparam logic [1:0] TIMER_DONE    = 2'd1;
	localparam logic [1:0] TIMER_ERROR   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MIN_PERSON_PIXELS   = 2'd0;
	localparam logic [1:0] CFG_MAX_DISTANCE_TENTHS = 2'd1;
	localparam logic [1:0] CFG_CYCLE_SECONDS       = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [6:0]  MIN_PERSON_PIXELS_RST   = 7'd4;
	localparam logic [11:0] MAX_DISTANCE_TENTHS_RST = 12'd250;

	// Display patterns.
	localparam logic [7:0] DISP_FAULT_ENTRY = 8'h3F;
	localparam logic [7:0] DISP_FAULT_HOLD  = 8'h7F;
	localparam logic [7:0] DISP_RUNNING     = 8'h80;
	localparam logic [7:0] DISP_INIT        = 8'h01;
	localparam logic [7:0] DISP_OPENING     = 8'h82;
	localparam logic [7:0] DISP_WAIT_OBJ    = 8'h02;
	localparam logic [7:0] DISP_VERIFY      = 8'h03;
	localparam logic [7:0] DISP_RELEASE     = 8'h06;

	// Report points within each minute.
	localparam logic [5:0] REPORT_SEC_A = 6'd0;
	localparam logic [5:0] REPORT_SEC_B = 6'd30;

	typedef struct packed {
		logic        ready_button;
		logic        clear_button;
		logic        fault_button;
		logic [1:0]  command;
		logic        door_closed;
		logic [6:0]  warm_pixels;
		logic [11:0] distance_tenths;
		logic [1:0]  timer_status;
		logic [15:0] secs_remaining;
		logic [6:0]  secs_elapsed;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  state_code;
		logic [7:0]  display_bits;
		logic        lamp_on;
		logic        lock_pulse;
		logic        unlock_drive;
		logic        start_timer;
		logic [2:0]  fault_code;
		logic        state_changed;
		logic [2:0]  warn_bits;
		logic        report_time;
		logic [10:0] report_minutes;
		logic [5:0]  report_seconds;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_write_t;

endpackage

[src/uvc_chan_if.sv]
// Valid/ready channel carrying one payload item per handshake.
interface uvc_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/uvc_time_split.sv]
// Splits a remaining time in seconds into whole minutes and leftover seconds.
module uvc_time_split (
	input  logic [15:0] secs,
	output logic [10:0] minutes,
	output logic [5:0]  seconds
);

	// secs / 60 == (secs / 4) / 15; the reciprocal of 15 scaled by 2^19 is
	// exact for every 14-bit dividend.
	localparam logic [15:0] RECIP_15 = 16'd34953;

	logic [13:0] quarter;
	logic [29:0] product;
	logic [16:0] min_times_60;
	logic [16:0] remainder;

	assign quarter      = secs[15:2];
	assign product      = 30'(quarter) * 30'(RECIP_15);
	assign minutes      = product[29:19];
	assign min_times_60 = {minutes, 6'b0} - {4'b0, minutes, 2'b0};
	assign remainder    = {1'b0, secs} - min_times_60;
	assign seconds      = remainder[5:0];

endmodule

[src/uv_chamber_cycle_controller_core.sv]
// UV chamber cycle controller: top level with the disinfection sequencer.
// This block runs a seven-state disinfection sequence (init, door opening,
// wait for object, verify chamber, active cycle, wait for release, fault)
// and advances it by one tick for every input item, producing exactly one
// result item per tick. Each result carries the state after the tick, the
// eight status LEDs, the lamp, lock and unlock drives, the timer start
// strobe, the fault code, chamber warnings and a remaining-time report that
// is due every half minute of the active cycle. An item passes through two
// registers: the input stage, which also splits the remaining seconds into
// minutes and seconds, and the result register, where the sequencer state is
// updated at the same edge. The sequencer takes one item per clock cycle
// while no result is stalled. A result is valid once its item has passed
// the input stage and the result register. The input stays ready while a
// result waits only while the input stage is empty. Configuration writes
// are taken in any cycle and should only be made while the block is idle.
// Register 0 sets the person threshold, register 1 the door-open distance,
// and register 2, the cycle length, is taken and has no effect here because
// the cycle timer that loads it sits outside this block.
module uv_chamber_cycle_controller_core (
	input  logic       clk,
	input  logic       arst_n,
	uvc_chan_if.sink   item,
	uvc_chan_if.source result,
	uvc_chan_if.sink   cfg
);

	// Sequencer states; their encodings are the published state codes.
	typedef enum logic [2:0] {
		S_INIT     = uvc_pkg::STATE_INIT,
		S_OPENING  = uvc_pkg::STATE_OPENING,
		S_WAIT_OBJ = uvc_pkg::STATE_WAIT_OBJ,
		S_VERIFY   = uvc_pkg::STATE_VERIFY,
		S_ACTIVE   = uvc_pkg::STATE_ACTIVE,
		S_RELEASE  = uvc_pkg::STATE_RELEASE,
		S_FAULT    = uvc_pkg::STATE_FAULTED
	} state_t;

	// Configuration registers.
	logic [6:0]  min_pixels_q;
	logic [11:0] open_limit_q;

	// Input stage.
	logic              s1_valid_q;
	uvc_pkg::in_item_t s1_item_s1;
	logic [10:0]       s1_minutes_s1;
	logic [5:0]        s1_seconds_s1;
	logic [10:0]       split_minutes;
	logic [5:0]        split_seconds;

	// Sequencer state and result register.
	state_t             state_q;
	logic [2:0]         fault_q;
	logic               warn_clear_q;
	logic [15:0]        last_report_q;
	logic               out_valid_q;
	uvc_pkg::out_item_t out_q;

	// Next-state logic.
	state_t             state_d;
	logic [2:0]         fault_d;
	logic               warn_clear_d;
	logic [15:0]        last_report_d;
	uvc_pkg::out_item_t out_d;
	logic               person;
	logic               door_open;
	logic               report_point;
	logic               advance;
	logic               item_take;

	// The sequencer advances whenever an item waits in the input stage and the
	// result register is free or is being emptied in this cycle.
	assign advance   = s1_valid_q && (!out_valid_q || result.ready);
	assign item.ready = !s1_valid_q || advance;
	assign item_take = item.valid && item.ready;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;
	assign cfg.ready    = 1'b1;

	uvc_time_split u_time_split (
		.secs    (item.data.secs_remaining),
		.minutes (split_minutes),
		.seconds (split_seconds)
	);

	always_ff @(posedge clk) begin
		if (item_take) begin
			s1_item_s1    <= item.data;
			s1_minutes_s1 <= split_minutes;
			s1_seconds_s1 <= split_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pixels_q <= uvc_pkg::MIN_PERSON_PIXELS_RST;
			open_limit_q <= uvc_pkg::MAX_DISTANCE_TENTHS_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				uvc_pkg::CFG_MIN_PERSON_PIXELS:   min_pixels_q <= cfg.data.data[6:0];
				uvc_pkg::CFG_MAX_DISTANCE_TENTHS: open_limit_q <= cfg.data.data[11:0];
				default: ;
			endcase
		end
	end

	// Chamber checks used in the verify state.
	assign person    = s1_item_s1.warm_pixels >= min_pixels_q;
	assign door_open = s1_item_s1.distance_tenths > open_limit_q;

	// A multiple of 30 seconds leaves 0 or 30 seconds past the whole minute.
	assign report_point = (s1_seconds_s1 == uvc_pkg::REPORT_SEC_A) ||
		(s1_seconds_s1 == uvc_pkg::REPORT_SEC_B);

	always_comb begin
		state_d       = state_q;
		fault_d       = fault_q;
		warn_clear_d  = warn_clear_q;
		last_report_d = last_report_q;
		out_d         = '0;

		if (state_q == S_FAULT) begin
			// Only a clear or a release command leaves the fault state; the
			// fault button has no further effect here.
			if (s1_item_s1.clear_button || s1_item_s1.command == uvc_pkg::CMD_RELEASE) begin
				fault_d             = uvc_pkg::FAULT_NONE;
				state_d             = S_INIT;
				warn_clear_d        = 1'b0;
				out_d.state_changed = 1'b1;
			end else begin
				out_d.display_bits = uvc_pkg::DISP_FAULT_HOLD;
			end
		end else if (!(state_q inside {[S_INIT:S_RELEASE]})) begin
			// A corrupted state code forces the fault state.
			fault_d             = uvc_pkg::FAULT_INVALID;
			state_d             = S_FAULT;
			warn_clear_d        = 1'b0;
			out_d.state_changed = 1'b1;
			out_d.display_bits  = uvc_pkg::DISP_FAULT_ENTRY;
		end else if (s1_item_s1.fault_button) begin
			// The manual fault preempts the rest of the tick and keeps the
			// previous fault code.
			state_d             = S_FAULT;
			warn_clear_d        = 1'b0;
			out_d.state_changed = 1'b1;
			out_d.display_bits  = uvc_pkg::DISP_FAULT_ENTRY;
		end else begin
			out_d.display_bits = uvc_pkg::DISP_RUNNING;
			case (state_q)
				S_INIT: begin
					if (s1_item_s1.ready_button ||
						s1_item_s1.command == uvc_pkg::CMD_START) begin
						state_d             = S_OPENING;
						warn_clear_d        = 1'b0;
						out_d.state_changed = 1'b1;
						fault_d             = uvc_pkg::FAULT_NONE;
					end else begin
						out_d.display_bits = out_d.display_bits | uvc_pkg::DISP_INIT;
					end
				end
				S_OPENING: begin
					out_d.unlock_drive = 1'b1;
					if (!s1_item_s1.door_closed) begin
						state_d             = S_WAIT_OBJ;
						warn_clear_d        = 1'b0;
						out_d.state_changed = 1'b1;
					end else begin
						out_d.display_bits = out_d.display_bits | uvc_pkg::DISP_OPENING;
					end
				end
				S_WAIT_OBJ: begin
					if (s1_item_s1.door_closed) begin
						out_d.lock_pulse    = 1'b1;
						state_d             = S_VERIFY;
						warn_clear_d        = 1'b0;
						out_d.state_changed = 1'b1;
					end else begin
						out_d.display_bits = out_d.display_bits | uvc_pkg::DISP_WAIT_OBJ;
					end
				end
				S_VERIFY: begin
					if ((s1_item_s1.command == uvc_pkg::CMD_START ||
						s1_item_s1.ready_button) && !person && !door_open) begin
						state_d             = S_ACTIVE;
						warn_clear_d        = 1'b0;
						out_d.state_changed = 1'b1;
						out_d.start_timer   = 1'b1;
					end else begin
						if (person) begin
							out_d.warn_bits[0] = 1'b1;
							warn_clear_d       = 1'b0;
						end
						if (door_open) begin
							out_d.warn_bits[1] = 1'b1;
							warn_clear_d       = 1'b0;
						end
						// The all-clear warning is given once until a problem
						// or a transition rearms it.
						if (!person && !door_open && !warn_clear_q) begin
							out_d.warn_bits[2] = 1'b1;
							warn_clear_d       = 1'b1;
						end
						if (!s1_item_s1.door_closed) begin
							state_d             = S_WAIT_OBJ;
							warn_clear_d        = 1'b0;
							out_d.state_changed = 1'b1;
						end else begin
							out_d.display_bits = out_d.display_bits | uvc_pkg::DISP_VERIFY;
						end
					end
				end
				S_ACTIVE: begin
					if (!s1_item_s1.door_closed) begin
						fault_d             = uvc_pkg::FAULT_DOOR_AJAR;
						state_d             = S_FAULT;
						warn_clear_d        = 1'b0;
						out_d.state_changed = 1'b1;
						out_d.display_bits  = uvc_pkg::DISP_FAULT_ENTRY;
					end else if (s1_item_s1.timer_status == uvc_pkg::TIMER_ERROR) begin
						fault_d             = uvc_pkg::FAULT_TIMER;
						state_d             = S_FAULT;
						warn_clear_d        = 1'b0;
						out_d.state_changed = 1'b1;
						out_d.display_bits  = uvc_pkg::DISP_FAULT_ENTRY;
					end else if (s1_item_s1.timer_status == uvc_pkg::TIMER_DONE ||
						s1_item_s1.command == uvc_pkg::CMD_END) begin
						state_d             = S_RELEASE;
						warn_clear_d        = 1'b0;
						out_d.state_changed = 1'b1;
					end else begin
						// Report each half-minute point once, even if the
						// timer holds the same value for several ticks.
						if (last_report_q != s1_item_s1.secs_remaining && report_point) begin
							out_d.report_time    = 1'b1;
							out_d.report_minutes = s1_minutes_s1;
							out_d.report_seconds = s1_seconds_s1;
							last_report_d        = s1_item_s1.secs_remaining;
						end
						out_d.lamp_on      = 1'b1;
						out_d.display_bits = {1'b0, s1_item_s1.secs_elapsed};
					end
				end
				S_RELEASE: begin
					if (s1_item_s1.ready_button ||
						s1_item_s1.command == uvc_pkg::CMD_RELEASE) begin
						state_d             = S_OPENING;
						warn_clear_d        = 1'b0;
						out_d.state_changed = 1'b1;
					end else begin
						out_d.display_bits = out_d.display_bits | uvc_pkg::DISP_RELEASE;
					end
				end
				default: ;
			endcase
		end

		out_d.state_code = state_d;
		out_d.fault_code = fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			state_q       <= S_INIT;
			fault_q       <= uvc_pkg::FAULT_UNSET;
			warn_clear_q  <= 1'b0;
			last_report_q <= '0;
			out_q         <= '0;
		end else begin
			if (item_take) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end

			if (advance) begin
				out_valid_q   <= 1'b1;
				out_q         <= out_d;
				state_q       <= state_d;
				fault_q       <= fault_d;
				warn_clear_q  <= warn_clear_d;
				last_report_q <= last_report_d;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/uvc_checker.sv]
// Port-level checker for the UV chamber controller and its bind statement.
`include "uv_chamber_cycle_controller_core_defines.svh"

module uvc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input uvc_pkg::out_item_t result_data
);

	logic result_stall;
	logic lamp_shown;
	logic report_shown;
	logic start_shown;
	logic clean_active;
	logic half_minute;
	logic active_entry;

	assign result_stall = result_valid && !result_ready;
	assign lamp_shown   = result_valid && result_data.lamp_on;
	assign report_shown = result_valid && result_data.report_time;
	assign start_shown  = result_valid && result_data.start_timer;

	assign clean_active = result_data.state_code == uvc_pkg::STATE_ACTIVE &&
		result_data.fault_code == uvc_pkg::FAULT_NONE;
	assign half_minute  = result_data.lamp_on &&
		(result_data.report_seconds == uvc_pkg::REPORT_SEC_A ||
		result_data.report_seconds == uvc_pkg::REPORT_SEC_B);
	assign active_entry = result_data.state_changed &&
		result_data.state_code == uvc_pkg::STATE_ACTIVE && !result_data.lamp_on;

	// A stalled result holds until it is taken.
	`UVC_ASSERT_NEXT(a_result_hold, result_stall, result_valid && $stable(result_data), "result changed while stalled")

	// The lamp only burns in the active cycle, which is never reached with a fault pending.
	`UVC_ASSERT_NOW(a_lamp_active, lamp_shown, clean_active, "lamp on outside a clean active cycle")

	// Reports fall on half-minute points of a lit cycle.
	`UVC_ASSERT_NOW(a_report_point, report_shown, half_minute, "report off a half-minute point")

	// The timer is started only on the transition into the active cycle.
	`UVC_ASSERT_NOW(a_start_entry, start_shown, active_entry, "timer start without entry")

endmodule

bind uv_chamber_cycle_controller_core uvc_checker u_uvc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
